/* sv/smi_pkg.sv */
`timescale 1ns / 1ps
// smi_pkg: shared types and constants of the small matrix inverse block
// depends on nothing; used by every module of the block
package smi_pkg;

   // configuration register indexes
   localparam int CSR_ADDR_WIDTH = 1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_MATRIX_SIZE  = 1'b0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_DET_THRESHOLD = 1'b1;
   localparam int THRESHOLD_WIDTH = 31;

   // order codes
   localparam logic [1:0] ORDER_ONE   = 2'd1;
   localparam logic [1:0] ORDER_TWO   = 2'd2;
   localparam logic [1:0] ORDER_THREE = 2'd3;

   // cofactor i (row-major adjugate entry) is p*s - q*r, negated where flagged
   localparam int MINOR_P [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
   localparam int MINOR_Q [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
   localparam int MINOR_R [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
   localparam int MINOR_S [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
   localparam logic [8:0] MINOR_NEG = 9'h0AA;

   // per-entry control travelling with a division lane
   typedef struct packed {
      logic use_entry;   // entry inside the block and matrix not singular
      logic neg;         // quotient sign
   } lane_ctl_type;

endpackage

/* sv/smi_cofactor.sv */
`timescale 1ns / 1ps
// smi_cofactor: two pipeline stages, minor products then signed cofactors
// depends on smi_pkg
module smi_cofactor #(
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic [1:0]                    en,
   input  logic [1:0]                    order,
   input  logic signed [ELEMENT_WIDTH-1:0]   a_in [9],
   output logic signed [2*ELEMENT_WIDTH:0]   adj_out [9],
   output logic signed [ELEMENT_WIDTH-1:0]   row0_out [3],
   output logic signed [2*ELEMENT_WIDTH:0]   det_alt_out
);
   localparam int E  = ELEMENT_WIDTH;
   localparam int AW = 2*E + 1;

   logic signed [2*E-1:0] ps_ff [9];
   logic signed [2*E-1:0] qr_ff [9];
   logic signed [E-1:0]   a1_ff [9];
   logic signed [AW-1:0]  adj_in [9];
   logic signed [AW-1:0]  adj_ff [9];
   logic signed [AW-1:0]  m3 [9];
   logic signed [AW-1:0]  det_alt_in;
   logic signed [AW-1:0]  det_alt_ff;
   logic signed [E-1:0]   row0_ff [3];

   // stage 1: eighteen element products
   for (genvar i = 0; i < 9; i++) begin : g_prod
      always_ff @(posedge clock) begin
         if (en[0]) begin
            ps_ff[i] <= a_in[smi_pkg::MINOR_P[i]] * a_in[smi_pkg::MINOR_S[i]];
            qr_ff[i] <= a_in[smi_pkg::MINOR_Q[i]] * a_in[smi_pkg::MINOR_R[i]];
            a1_ff[i] <= a_in[i];
         end
      end
      always_comb begin
         if (smi_pkg::MINOR_NEG[i])
            m3[i] = {qr_ff[i][2*E-1], qr_ff[i]} - {ps_ff[i][2*E-1], ps_ff[i]};
         else
            m3[i] = {ps_ff[i][2*E-1], ps_ff[i]} - {qr_ff[i][2*E-1], qr_ff[i]};
      end
   end

   // stage 2: cofactors for the order in use
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         adj_in[i] = (order == smi_pkg::ORDER_THREE) ? m3[i] : '0;
      end
      det_alt_in = {{(AW-E){a1_ff[0][E-1]}}, a1_ff[0]};
      case (order)
         smi_pkg::ORDER_THREE: begin
         end
         smi_pkg::ORDER_TWO: begin
            adj_in[0] = {{(AW-E){a1_ff[4][E-1]}}, a1_ff[4]};
            adj_in[1] = -{{(AW-E){a1_ff[1][E-1]}}, a1_ff[1]};
            adj_in[3] = -{{(AW-E){a1_ff[3][E-1]}}, a1_ff[3]};
            adj_in[4] = {{(AW-E){a1_ff[0][E-1]}}, a1_ff[0]};
            det_alt_in = m3[8];
         end
         default: begin
            adj_in[0] = AW'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         adj_ff     <= adj_in;
         det_alt_ff <= det_alt_in;
         for (int j = 0; j < 3; j++) begin
            row0_ff[j] <= a1_ff[j];
         end
      end
   end

   assign adj_out     = adj_ff;
   assign row0_out    = row0_ff;
   assign det_alt_out = det_alt_ff;

endmodule

/* sv/smi_det.sv */
`timescale 1ns / 1ps
// smi_det: three stages, row-0 expansion products, determinant sum, and
// magnitude / threshold / saturation prep for the division lanes; uses smi_pkg
module smi_det #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRAC_BITS     = 16
) (
   input  logic                              clock,
   input  logic [2:0]                        en,
   input  logic [1:0]                        order,
   input  logic [smi_pkg::THRESHOLD_WIDTH-1:0] threshold,
   input  logic signed [2*ELEMENT_WIDTH:0]   adj_in [9],
   input  logic signed [ELEMENT_WIDTH-1:0]   row0_in [3],
   input  logic signed [2*ELEMENT_WIDTH:0]   det_alt_in,
   output logic [2*ELEMENT_WIDTH:0]          num_mag [9],
   output logic [3*ELEMENT_WIDTH+2:0]        det_mag,
   output smi_pkg::lane_ctl_type             ctl [9],
   output logic [ELEMENT_WIDTH-1:0]          det_sat,
   output logic                              sing
);
   localparam int E  = ELEMENT_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int AW = 2*E + 1;
   localparam int DW = 3*E + 3;
   localparam logic [E-1:0] SAT_MAX = {1'b0, {(E-1){1'b1}}};
   localparam logic [E-1:0] SAT_MIN = {1'b1, {(E-1){1'b0}}};

   logic signed [AW-1:0] lo_ff [3];
   logic signed [AW-1:0] hi_ff [3];
   logic signed [AW-1:0] adj3_ff [9];
   logic signed [AW-1:0] adj4_ff [9];
   logic signed [AW-1:0] alt3_ff;
   logic signed [DW-1:0] det_in;
   logic signed [DW-1:0] det_ff;

   logic [DW-1:0] abs_det;
   logic [DW-1:0] dq_mag;
   logic          sing_in;
   logic          big_dq;
   logic [E-1:0]  det_sat_in;

   logic [AW-1:0]         num_mag_ff [9];
   logic [DW-1:0]         det_mag_ff;
   smi_pkg::lane_ctl_type ctl_ff [9];
   logic [E-1:0]          det_sat_ff;
   logic                  sing_ff;

   // stage 3: each row-0 cofactor split into a low unsigned and a high signed half
   for (genvar j = 0; j < 3; j++) begin : g_part
      logic signed [E:0] c_lo;
      logic signed [E:0] c_hi;
      assign c_lo = $signed({1'b0, adj_in[3*j][E-1:0]});
      assign c_hi = adj_in[3*j][AW-1:E];
      always_ff @(posedge clock) begin
         if (en[0]) begin
            lo_ff[j] <= row0_in[j] * c_lo;
            hi_ff[j] <= row0_in[j] * c_hi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         adj3_ff <= adj_in;
         alt3_ff <= det_alt_in;
      end
   end

   // stage 4: determinant
   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + ({{(DW-AW){hi_ff[j][AW-1]}}, hi_ff[j]} <<< E)
                         + {{(DW-AW){lo_ff[j][AW-1]}}, lo_ff[j]};
      end
      if (order != smi_pkg::ORDER_THREE)
         det_in = {{(DW-AW){alt3_ff[AW-1]}}, alt3_ff};
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         det_ff  <= det_in;
         adj4_ff <= adj3_ff;
      end
   end

   // stage 5: truncated magnitude, singular test, saturation
   always_comb begin
      abs_det = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      case (order)
         smi_pkg::ORDER_THREE: dq_mag = abs_det >> (2*F);
         smi_pkg::ORDER_TWO:   dq_mag = abs_det >> F;
         default:              dq_mag = abs_det;
      endcase
      sing_in = dq_mag <= {{(DW-smi_pkg::THRESHOLD_WIDTH){1'b0}}, threshold};
      big_dq  = dq_mag >= (DW'(1) << (E-1));
      if (det_ff[DW-1])
         det_sat_in = big_dq ? SAT_MIN : -dq_mag[E-1:0];
      else
         det_sat_in = big_dq ? SAT_MAX : dq_mag[E-1:0];
   end

   for (genvar i = 0; i < 9; i++) begin : g_prep
      localparam logic [1:0] ROW = 2'(i / 3);
      localparam logic [1:0] COL = 2'(i % 3);
      logic eff_order_gt_row;
      logic eff_order_gt_col;
      // order zero behaves as order one
      assign eff_order_gt_row = (ROW < order) || (ROW == 2'd0);
      assign eff_order_gt_col = (COL < order) || (COL == 2'd0);
      always_ff @(posedge clock) begin
         if (en[2]) begin
            num_mag_ff[i] <= adj4_ff[i][AW-1] ? AW'(-adj4_ff[i]) : AW'(adj4_ff[i]);
            ctl_ff[i].use_entry <= eff_order_gt_row && eff_order_gt_col && !sing_in;
            ctl_ff[i].neg       <= adj4_ff[i][AW-1] ^ det_ff[DW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         det_mag_ff <= abs_det;
         det_sat_ff <= det_sat_in;
         sing_ff    <= sing_in;
      end
   end

   assign num_mag = num_mag_ff;
   assign det_mag = det_mag_ff;
   assign ctl     = ctl_ff;
   assign det_sat = det_sat_ff;
   assign sing    = sing_ff;

endmodule

/* sv/smi_div_lane.sv */
`timescale 1ns / 1ps
// smi_div_lane: pipelined restoring divider for one inverse entry,
// overflow check, one quotient bit per stage, saturating output; uses smi_pkg
module smi_div_lane #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRAC_BITS     = 16
) (
   input  logic                          clock,
   input  logic [ELEMENT_WIDTH+1:0]      en,
   input  logic [2*ELEMENT_WIDTH:0]      num_mag,
   input  logic [3*ELEMENT_WIDTH+2:0]    det_mag,
   input  smi_pkg::lane_ctl_type         ctl,
   output logic [ELEMENT_WIDTH-1:0]      quot
);
   localparam int E  = ELEMENT_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int AW = 2*E + 1;
   localparam int DW = 3*E + 3;
   localparam int NW = AW + 2*F;
   localparam int XW = ((NW > DW + E) ? NW : DW + E) + 1;
   localparam logic [E-1:0] SAT_MAX = {1'b0, {(E-1){1'b1}}};
   localparam logic [E-1:0] SAT_MIN = {1'b1, {(E-1){1'b0}}};

   logic [XW-1:0]         rem_ff [E+1];
   logic [DW-1:0]         dv_ff  [E+1];
   logic [E-1:0]          q_ff   [E+1];
   logic                  ovf_ff [E+1];
   smi_pkg::lane_ctl_type ctl_ff [E+1];
   logic [E-1:0]          quot_ff;

   logic [XW-1:0] num_ext;
   logic [XW-1:0] dsh0;
   assign num_ext = {{(XW-AW){1'b0}}, num_mag} << (2*F);
   assign dsh0    = {{(XW-DW){1'b0}}, det_mag} << E;

   // quotient of 2^E or more saturates whenever the entry is in use
   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= num_ext;
         dv_ff[0]  <= det_mag;
         q_ff[0]   <= '0;
         ovf_ff[0] <= num_ext >= dsh0;
         ctl_ff[0] <= ctl;
      end
   end

   for (genvar j = 1; j <= E; j++) begin : g_step
      logic [XW-1:0] dsh;
      logic          take;
      logic [E-1:0]  q_in;
      assign dsh  = {{(XW-DW){1'b0}}, dv_ff[j-1]} << (E-j);
      assign take = rem_ff[j-1] >= dsh;
      always_comb begin
         q_in        = q_ff[j-1];
         q_in[E-j]   = take;
      end
      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= take ? rem_ff[j-1] - dsh : rem_ff[j-1];
            dv_ff[j]  <= dv_ff[j-1];
            q_ff[j]   <= q_in;
            ovf_ff[j] <= ovf_ff[j-1];
            ctl_ff[j] <= ctl_ff[j-1];
         end
      end
   end

   // a magnitude of exactly 2^(E-1) negated is the most negative value anyway
   always_ff @(posedge clock) begin
      if (en[E+1]) begin
         if (!ctl_ff[E].use_entry)
            quot_ff <= '0;
         else if (ctl_ff[E].neg)
            quot_ff <= (ovf_ff[E] || q_ff[E][E-1]) ? SAT_MIN : -q_ff[E];
         else
            quot_ff <= (ovf_ff[E] || q_ff[E][E-1]) ? SAT_MAX : q_ff[E];
      end
   end

   assign quot = quot_ff;

endmodule

/* sv/small_matrix_inverse_det.sv */
`timescale 1ns / 1ps
// small_matrix_inverse_det: determinant and inverse of a 1x1, 2x2 or 3x3
// fixed-point matrix. depends on smi_pkg, smi_cofactor, smi_det, smi_div_lane
//
// One matrix per transfer, nine row-major signed elements, one result per
// matrix in the same order. The block is a fully pipelined datapath of
// ELEMENT_WIDTH+8 register stages (40 at the default width): an input register,
// two stages form the minor products and cofactors, three form the determinant
// by row-0 expansion and prepare magnitudes, and nine parallel restoring
// dividers each spend one overflow stage plus one stage per quotient bit before
// a saturating output register. A new matrix may be accepted every cycle
// unless every stage is full and rsp_tready is low. Each stage carries its
// own valid bit and moves as soon as the stage after it has room, so holding
// rsp_tready low only stops the pipeline once every stage is full, and gaps
// between transfers collapse. The determinant is exact before truncation
// toward zero; each inverse entry is the exact cofactor times 2^(2*FRAC_BITS)
// divided by the exact determinant, truncated toward zero and saturated. When
// the truncated determinant magnitude is at or below det_threshold the result
// is flagged singular and all inverse entries read zero. Entries outside the
// order in use read zero. matrix_size 0 acts as order 1. The user must write
// registers only while no matrix is in flight; the block does not enforce it.
module small_matrix_inverse_det #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRAC_BITS     = 16,
   localparam int IW = ((9*ELEMENT_WIDTH + 7) / 8) * 8,
   localparam int OW = ((10*ELEMENT_WIDTH + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // matrix in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // elem_r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2, zero pad
   input  logic [IW-1:0]                      req_tdata,
   // result out
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // det_value, inv_r0c0 .. inv_r2c2 (row-major), zero pad
   output logic [OW-1:0]                      rsp_tdata,
   // singular
   output logic [0:0]                         rsp_tuser,
   // register writes
   input  logic                               csr_we,
   input  logic [smi_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [smi_pkg::THRESHOLD_WIDTH-1:0] csr_wdata
);
   localparam int E  = ELEMENT_WIDTH;
   localparam int AW = 2*E + 1;
   localparam int DW = 3*E + 3;
   localparam int NS = E + 8;   // total register stages
   localparam int LS = E + 2;   // stages inside a division lane
   localparam int DIV_FIRST = 6;

   // configuration registers
   logic [1:0]                          size_ff;
   logic [smi_pkg::THRESHOLD_WIDTH-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= smi_pkg::ORDER_THREE;
         thr_ff  <= smi_pkg::THRESHOLD_WIDTH'(1);
      end else if (csr_we) begin
         case (csr_addr)
            smi_pkg::CSR_MATRIX_SIZE:   size_ff <= csr_wdata[1:0];
            smi_pkg::CSR_DET_THRESHOLD: thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valid bits; a stage loads when it is empty or everything after it
   // can move
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] rdy;

   for (genvar k = 0; k < NS; k++) begin : g_rdy
      assign rdy[k] = rsp_tready || !(&vld_ff[NS-1:k]);
   end

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (!rdy[k])
            vld_in[k] = vld_ff[k];
         else if (k == 0)
            vld_in[k] = req_tvalid;
         else
            vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NS-1];

   // stage 0: input register
   logic signed [E-1:0] a_ff [9];
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int i = 0; i < 9; i++) begin
            a_ff[i] <= req_tdata[i*E +: E];
         end
      end
   end

   // stages 1-2: cofactors
   logic signed [AW-1:0] adj [9];
   logic signed [E-1:0]  row0 [3];
   logic signed [AW-1:0] det_alt;

   smi_cofactor #(
      .ELEMENT_WIDTH(E)
   ) u_cofactor (
      .clock       (clock),
      .en          (rdy[2:1]),
      .order       (size_ff),
      .a_in        (a_ff),
      .adj_out     (adj),
      .row0_out    (row0),
      .det_alt_out (det_alt)
   );

   // stages 3-5: determinant and divider operands
   logic [AW-1:0]         num_mag [9];
   logic [DW-1:0]         det_mag;
   smi_pkg::lane_ctl_type ctl [9];
   logic [E-1:0]          det_sat;
   logic                  sing;

   smi_det #(
      .ELEMENT_WIDTH(E),
      .FRAC_BITS    (FRAC_BITS)
   ) u_det (
      .clock      (clock),
      .en         (rdy[5:3]),
      .order      (size_ff),
      .threshold  (thr_ff),
      .adj_in     (adj),
      .row0_in    (row0),
      .det_alt_in (det_alt),
      .num_mag    (num_mag),
      .det_mag    (det_mag),
      .ctl        (ctl),
      .det_sat    (det_sat),
      .sing       (sing)
   );

   // stages 6 and up: nine division lanes
   logic [E-1:0] inv [9];
   for (genvar i = 0; i < 9; i++) begin : g_lane
      smi_div_lane #(
         .ELEMENT_WIDTH(E),
         .FRAC_BITS    (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .en      (rdy[NS-1:DIV_FIRST]),
         .num_mag (num_mag[i]),
         .det_mag (det_mag),
         .ctl     (ctl[i]),
         .quot    (inv[i])
      );
   end

   // determinant and singular flag ride alongside the lanes
   logic [E-1:0] side_det_ff  [LS];
   logic         side_sing_ff [LS];
   for (genvar s = 0; s < LS; s++) begin : g_side
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (rdy[DIV_FIRST]) begin
               side_det_ff[0]  <= det_sat;
               side_sing_ff[0] <= sing;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (rdy[DIV_FIRST + s]) begin
               side_det_ff[s]  <= side_det_ff[s-1];
               side_sing_ff[s] <= side_sing_ff[s-1];
            end
         end
      end
   end

   assign rsp_tdata = OW'({inv[8], inv[7], inv[6], inv[5], inv[4], inv[3],
                           inv[2], inv[1], inv[0], side_det_ff[LS-1]});
   assign rsp_tuser = side_sing_ff[LS-1];

endmodule

/* sv/smi_checker.sv */
`timescale 1ns / 1ps
// smi_checker: port-level assertions for small_matrix_inverse_det
// depends on smi_pkg; bound to the top level at the end of this file
module smi_checker #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRAC_BITS     = 16,
   localparam int IW = ((9*ELEMENT_WIDTH + 7) / 8) * 8,
   localparam int OW = ((10*ELEMENT_WIDTH + 7) / 8) * 8
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [IW-1:0]                      req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [OW-1:0]                      rsp_tdata,
   input logic [0:0]                         rsp_tuser,
   input logic                               csr_we,
   input logic [smi_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input logic [smi_pkg::THRESHOLD_WIDTH-1:0] csr_wdata
);
   localparam int E = ELEMENT_WIDTH;

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // no input stall without output back-pressure
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output ready");

   // singular results carry a zero inverse
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[10*E-1:E] == '0)
      else $error("singular result with nonzero inverse");

   // a zero determinant is always singular
   a_zero_det: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[E-1:0] == '0 |-> rsp_tuser[0])
      else $error("zero determinant not flagged singular");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                     && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind small_matrix_inverse_det smi_checker #(
   .ELEMENT_WIDTH(ELEMENT_WIDTH),
   .FRAC_BITS    (FRAC_BITS)
) u_smi_checker (.*);
